@@ rtl/core/pad_chord_filter_unit_assert.svh @@
// ----------------------------------------------------------------------------
// pad_chord_filter_unit_assert.svh
// Assertion macros used by the chord filter RTL.
// ----------------------------------------------------------------------------
`ifndef PAD_CHORD_FILTER_UNIT_ASSERT_SVH
`define PAD_CHORD_FILTER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PCF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pad chord filter check failed");

// Next-cycle implication, checked outside reset.
`define PCF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pad chord filter check failed");

`endif

@@ rtl/core/pcf_pkg.sv @@
// ----------------------------------------------------------------------------
// pcf_pkg
// Widths, register indexes, reset values and bundle types of the chord filter.
// ----------------------------------------------------------------------------
package pcf_pkg;

  localparam int TICK_BITS   = 32;
  localparam int BUTTON_BITS = 16;
  localparam int AXIS_BITS   = 16;
  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_IDX_BITS  = 3;

  localparam logic [BUTTON_BITS-1:0] SELECT_MASK_RESET = BUTTON_BITS'(256);
  localparam logic [BUTTON_BITS-1:0] START_MASK_RESET  = BUTTON_BITS'(512);
  localparam logic [BUTTON_BITS-1:0] L1_MASK_RESET     = BUTTON_BITS'(16);
  localparam logic [15:0]            HOLD_OFF_RESET    = 16'd400;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_ENABLE_FILTER = 3'd0,
    REG_SELECT_MASK   = 3'd1,
    REG_START_MASK    = 3'd2,
    REG_L1_MASK       = 3'd3,
    REG_HOLD_OFF      = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic                   enable_filter;
    logic [BUTTON_BITS-1:0] select_mask;
    logic [BUTTON_BITS-1:0] start_mask;
    logic [BUTTON_BITS-1:0] l1_mask;
    logic [15:0]            hold_off_ticks;
  } cfg_t;

  typedef struct packed {
    logic [TICK_BITS-1:0]        tick_now;
    logic                        pad_index;
    logic [BUTTON_BITS-1:0]      buttons;
    logic signed [AXIS_BITS-1:0] left_x;
    logic signed [AXIS_BITS-1:0] left_y;
    logic signed [AXIS_BITS-1:0] right_x;
    logic signed [AXIS_BITS-1:0] right_y;
  } poll_t;

  typedef struct packed {
    logic [BUTTON_BITS-1:0]      buttons;
    logic signed [AXIS_BITS-1:0] left_x;
    logic signed [AXIS_BITS-1:0] left_y;
    logic signed [AXIS_BITS-1:0] right_x;
    logic signed [AXIS_BITS-1:0] right_y;
    logic                        menu_request;
    logic                        chord_swallowed;
  } result_t;

endpackage

@@ rtl/core/pcf_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// pcf_cfg_regs
// Configuration register file of the chord filter, written by index.
// ----------------------------------------------------------------------------
module pcf_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [pcf_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [pcf_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
  output pcf_pkg::cfg_t                       cfg
);

  pcf_pkg::cfg_t cfg_r;
  pcf_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        pcf_pkg::REG_ENABLE_FILTER: cfg_nxt.enable_filter = cfg_wdata[0];
        pcf_pkg::REG_SELECT_MASK:
          cfg_nxt.select_mask = cfg_wdata[pcf_pkg::BUTTON_BITS-1:0];
        pcf_pkg::REG_START_MASK:
          cfg_nxt.start_mask = cfg_wdata[pcf_pkg::BUTTON_BITS-1:0];
        pcf_pkg::REG_L1_MASK:
          cfg_nxt.l1_mask = cfg_wdata[pcf_pkg::BUTTON_BITS-1:0];
        pcf_pkg::REG_HOLD_OFF:      cfg_nxt.hold_off_ticks = cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable_filter  <= 1'b0;
      cfg_r.select_mask    <= pcf_pkg::SELECT_MASK_RESET;
      cfg_r.start_mask     <= pcf_pkg::START_MASK_RESET;
      cfg_r.l1_mask        <= pcf_pkg::L1_MASK_RESET;
      cfg_r.hold_off_ticks <= pcf_pkg::HOLD_OFF_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ rtl/core/pcf_filter_core.sv @@
// ----------------------------------------------------------------------------
// pcf_filter_core
// Chord decision logic and the filter state, updated once per poll.
// ----------------------------------------------------------------------------
module pcf_filter_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step_en,
  input  pcf_pkg::cfg_t    cfg,
  input  pcf_pkg::poll_t   poll,
  output pcf_pkg::result_t result
);

  logic [pcf_pkg::TICK_BITS-1:0] hold_off_until_r, hold_off_until_nxt;
  logic                          select_withheld_r, select_withheld_nxt;
  logic                          menu_held_r, menu_held_nxt;

  logic [pcf_pkg::BUTTON_BITS-1:0] menu_keys;
  logic [pcf_pkg::BUTTON_BITS-1:0] scrub_chord;
  logic [pcf_pkg::BUTTON_BITS-1:0] partner;
  logic [pcf_pkg::TICK_BITS-1:0]   window_end;
  logic                            swallow;

  assign menu_keys   = cfg.select_mask | cfg.start_mask;
  assign scrub_chord = cfg.select_mask | cfg.l1_mask;
  assign partner     = cfg.start_mask | cfg.l1_mask;
  // The window end wraps with the tick counter.
  assign window_end  = poll.tick_now +
                       {{(pcf_pkg::TICK_BITS-16){1'b0}}, cfg.hold_off_ticks};

  always_comb begin
    hold_off_until_nxt  = hold_off_until_r;
    select_withheld_nxt = select_withheld_r;
    menu_held_nxt       = menu_held_r;
    swallow             = 1'b0;
    result.buttons         = poll.buttons;
    result.menu_request    = 1'b0;
    result.chord_swallowed = 1'b0;

    if (!cfg.enable_filter || poll.pad_index) begin
      // Pass-through leaves the state alone.
    end else if ((poll.buttons & menu_keys) == menu_keys) begin
      swallow             = 1'b1;
      result.menu_request = !menu_held_r;
      menu_held_nxt       = 1'b1;
      select_withheld_nxt = 1'b0;
      hold_off_until_nxt  = window_end;
    end else begin
      menu_held_nxt = 1'b0;
      if ((poll.buttons & scrub_chord) == scrub_chord) begin
        swallow             = 1'b1;
        select_withheld_nxt = 1'b0;
        hold_off_until_nxt  = window_end;
      end else if (poll.tick_now < hold_off_until_r) begin
        result.buttons = poll.buttons & ~(scrub_chord | menu_keys);
      end else if ((poll.buttons & cfg.select_mask) != '0) begin
        select_withheld_nxt = 1'b1;
        result.buttons      = poll.buttons & ~cfg.select_mask;
      end else if (select_withheld_r && ((poll.buttons & partner) != '0)) begin
        // A late partner rebuilds the chord that the withheld SELECT began.
        swallow             = 1'b1;
        result.menu_request = (poll.buttons & cfg.start_mask) != '0;
        select_withheld_nxt = 1'b0;
        hold_off_until_nxt  = window_end;
      end else if (select_withheld_r) begin
        select_withheld_nxt = 1'b0;
        result.buttons      = poll.buttons | cfg.select_mask;
      end
    end

    if (swallow) begin
      result.buttons = '0;
      result.left_x  = '0;
      result.left_y  = '0;
      result.right_x = '0;
      result.right_y = '0;
    end else begin
      result.left_x  = poll.left_x;
      result.left_y  = poll.left_y;
      result.right_x = poll.right_x;
      result.right_y = poll.right_y;
    end
    result.chord_swallowed = swallow;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_off_until_r  <= '0;
      select_withheld_r <= 1'b0;
      menu_held_r       <= 1'b0;
    end else if (step_en) begin
      hold_off_until_r  <= hold_off_until_nxt;
      select_withheld_r <= select_withheld_nxt;
      menu_held_r       <= menu_held_nxt;
    end
  end

endmodule

@@ rtl/core/pad_chord_filter_unit.sv @@
// ----------------------------------------------------------------------------
// pad_chord_filter_unit
// A poll accepted into the input register moves on to the result register, and
// so to the out_ ports, at the first edge that finds the result register free.
// Throughput: one poll per cycle; the input register and the result register
// advance together whenever the result register is empty or being taken.
// Reset (rst_n low, synchronous): pipeline emptied, filter state cleared,
// configuration registers back to their reset values.
// ----------------------------------------------------------------------------
`include "pad_chord_filter_unit_assert.svh"

module pad_chord_filter_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,

  input  logic                                  cfg_wr_en,
  input  logic [pcf_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [pcf_pkg::CFG_DATA_BITS-1:0]     cfg_wdata,

  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [pcf_pkg::TICK_BITS-1:0]         in_tick_now,
  input  logic                                  in_pad_index,
  input  logic [pcf_pkg::BUTTON_BITS-1:0]       in_buttons_in,
  input  logic signed [pcf_pkg::AXIS_BITS-1:0]  in_left_x_in,
  input  logic signed [pcf_pkg::AXIS_BITS-1:0]  in_left_y_in,
  input  logic signed [pcf_pkg::AXIS_BITS-1:0]  in_right_x_in,
  input  logic signed [pcf_pkg::AXIS_BITS-1:0]  in_right_y_in,

  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [pcf_pkg::BUTTON_BITS-1:0]       out_buttons_out,
  output logic signed [pcf_pkg::AXIS_BITS-1:0]  out_left_x_out,
  output logic signed [pcf_pkg::AXIS_BITS-1:0]  out_left_y_out,
  output logic signed [pcf_pkg::AXIS_BITS-1:0]  out_right_x_out,
  output logic signed [pcf_pkg::AXIS_BITS-1:0]  out_right_y_out,
  output logic                                  out_menu_request,
  output logic                                  out_chord_swallowed
);

  pcf_pkg::cfg_t    cfg;
  pcf_pkg::poll_t   poll_r;
  pcf_pkg::result_t core_result;
  pcf_pkg::result_t result_r;
  logic             poll_valid_r;
  logic             out_valid_r;
  logic             advance;
  logic             step_en;
  logic             out_fields_zero;

  pcf_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pcf_filter_core u_filter_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .cfg     (cfg),
    .poll    (poll_r),
    .result  (core_result)
  );

  // The result register loads when it is empty or its request is being taken.
  assign advance  = !out_valid_r || out_ready;
  assign step_en  = poll_valid_r && advance;
  assign in_ready = !poll_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_ready) begin
        poll_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= poll_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      poll_r.tick_now  <= in_tick_now;
      poll_r.pad_index <= in_pad_index;
      poll_r.buttons   <= in_buttons_in;
      poll_r.left_x    <= in_left_x_in;
      poll_r.left_y    <= in_left_y_in;
      poll_r.right_x   <= in_right_x_in;
      poll_r.right_y   <= in_right_y_in;
    end
    if (step_en) begin
      result_r <= core_result;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_buttons_out     = result_r.buttons;
  assign out_left_x_out      = result_r.left_x;
  assign out_left_y_out      = result_r.left_y;
  assign out_right_x_out     = result_r.right_x;
  assign out_right_y_out     = result_r.right_y;
  assign out_menu_request    = result_r.menu_request;
  assign out_chord_swallowed = result_r.chord_swallowed;

  assign out_fields_zero = (out_buttons_out == '0) && (out_left_x_out == '0) &&
                           (out_left_y_out == '0) && (out_right_x_out == '0) &&
                           (out_right_y_out == '0);

  // A menu request only comes with a swallowed poll.
  `PCF_ASSERT_NOW(a_menu_implies_swallow, out_valid && out_menu_request, out_chord_swallowed)
  // A swallowed poll carries no buttons and centered axes.
  `PCF_ASSERT_NOW(a_swallow_is_empty, out_valid && out_chord_swallowed, out_fields_zero)
  // With no result waiting, the input side never stalls.
  `PCF_ASSERT_NOW(a_ready_when_drained, !out_valid, in_ready)
  // A poll that steps the filter core is always valid in the result register in the following cycle.
  `PCF_ASSERT_NEXT(a_poll_advances, step_en, out_valid)

endmodule
